// ===== rtl/core/shk_pkg.sv =====
// Package for the selectable string key hash.
// Holds scheme codes, hash constants, datapath command types and helpers.
// No dependencies.
`default_nettype none

package shk_pkg;

    localparam logic [2:0] ALG_CRC32   = 3'd0;
    localparam logic [2:0] ALG_DJB2    = 3'd1;
    localparam logic [2:0] ALG_SDBM    = 3'd2;
    localparam logic [2:0] ALG_ROT     = 3'd3;
    localparam logic [2:0] ALG_FNV1A   = 3'd4;
    localparam logic [2:0] ALG_MURMUR  = 3'd5;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] DJB2_SEED = 32'd5381;
    localparam logic [31:0] FNV_SEED  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] MM_C1     = 32'hcc9e_2d51;
    localparam logic [31:0] MM_C2     = 32'h1b87_3593;
    localparam logic [31:0] MM_ADD    = 32'he654_6b64;
    localparam logic [31:0] MM_F1     = 32'h85eb_ca6b;
    localparam logic [31:0] MM_F2     = 32'hc2b2_ae35;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_ABSORB,
        DP_EMIT,
        DP_MM_K2,
        DP_MM_H,
        DP_FIN1,
        DP_FIN2,
        DP_FIN3
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_mm;
    } t_dp_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MM_K2,
        ST_MM_H,
        ST_FIN2,
        ST_FIN3
    } t_state;

    function automatic logic [31:0] seed_of(input logic [2:0] alg);
        logic [31:0] s;
        case (alg)
            ALG_DJB2:  s = DJB2_SEED;
            ALG_FNV1A: s = FNV_SEED;
            default:   s = 32'd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] c;
        c = h ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/shk_if.sv =====
// Stream interfaces for the selectable string key hash.
// Key word channel and hash word channel; valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface shk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       end_of_key;

    modport source (output valid, output key_byte, output end_of_key, input ready);
    modport sink   (input valid, input key_byte, input end_of_key, output ready);
endinterface

interface shk_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/selectable_string_key_hash.sv =====
// Selectable string key hash: one key byte per word, terminator word emits hash.
// crc32, djb2, sdbm, rotating and fnv1a finish each word when it is accepted;
// murmur-like adds K2 and H steps per byte, FIN2/FIN3 per terminator (multiply chain).
// The hash word appears in an output register the cycle after its terminator completes.
// Reset (i_rst_n low, synchronous): scheme crc32, running hash 0, no word pending.
// Depends on shk_pkg, shk_if, shk_ctrl, shk_datapath.
`default_nettype none

module selectable_string_key_hash (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [2:0] i_cfg_wr_data,
    shk_in_if.sink          i_key,
    shk_out_if.source       o_hash
);
    import shk_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    shk_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_key.valid),
        .i_end_of_key (i_key.end_of_key),
        .o_in_ready   (i_key.ready),
        .o_out_valid  (o_hash.valid),
        .i_out_ready  (o_hash.ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    shk_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_key_byte    (i_key.key_byte),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_hash_value  (o_hash.hash_value)
    );

endmodule

`default_nettype wire

// ===== rtl/core/shk_datapath.sv =====
// Datapath of the selectable string key hash: scheme register, running hash,
// multiply scratch register and output hash register.
// Depends on shk_pkg.
`default_nettype none

module shk_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [2:0]        i_cfg_wr_data,
    input  wire logic [7:0]        i_key_byte,
    input  wire shk_pkg::t_dp_cmd  i_cmd,
    output      shk_pkg::t_dp_stat o_stat,
    output      logic [31:0]       o_hash_value
);
    import shk_pkg::*;

    logic [2:0]  r_alg;
    logic [2:0]  n_alg;
    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] r_tmp;
    logic [31:0] n_tmp;
    logic [31:0] r_out;
    logic [31:0] n_out;
    logic [31:0] w_byte;
    logic [31:0] w_mix;
    logic [31:0] w_rot;

    assign w_byte = {24'd0, i_key_byte};
    assign w_mix  = r_hash ^ r_tmp;
    assign w_rot  = {w_mix[18:0], w_mix[31:19]};

    always_comb begin
        n_alg  = r_alg;
        n_hash = r_hash;
        n_tmp  = r_tmp;
        n_out  = r_out;
        case (i_cmd.op)
            DP_ABSORB: begin
                case (r_alg)
                    ALG_DJB2:   n_hash = (r_hash << 5) + r_hash + w_byte;
                    ALG_SDBM:   n_hash = w_byte + (r_hash << 6) + (r_hash << 16) - r_hash;
                    ALG_ROT:    n_hash = {r_hash[26:0], r_hash[31:27]} ^ w_byte;
                    ALG_FNV1A:  n_hash = (r_hash ^ w_byte) * FNV_PRIME;
                    ALG_MURMUR: n_tmp  = w_byte * MM_C1;
                    default:    n_hash = crc_byte(r_hash, i_key_byte);
                endcase
            end
            DP_MM_K2: n_tmp  = {r_tmp[16:0], r_tmp[31:17]} * MM_C2;
            DP_MM_H:  n_hash = w_rot + (w_rot << 2) + MM_ADD;
            DP_FIN1:  n_tmp  = (r_hash ^ (r_hash >> 16)) * MM_F1;
            DP_FIN2:  n_tmp  = (r_tmp ^ (r_tmp >> 13)) * MM_F2;
            DP_FIN3: begin
                n_out  = r_tmp ^ (r_tmp >> 16);
                n_hash = seed_of(r_alg);
            end
            DP_EMIT: begin
                n_out  = r_hash;
                n_hash = seed_of(r_alg);
            end
            default: ;
        endcase
        if (i_cfg_wr_en) begin
            n_alg  = i_cfg_wr_data;
            n_hash = seed_of(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg  <= ALG_CRC32;
            r_hash <= 32'd0;
        end else begin
            r_alg  <= n_alg;
            r_hash <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmp <= n_tmp;
        r_out <= n_out;
    end

    assign o_stat.is_mm = (r_alg == ALG_MURMUR);
    assign o_hash_value = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/shk_ctrl.sv =====
// Controller of the selectable string key hash: sequences multi-cycle
// murmur steps and owns the handshakes and output word valid.
// Depends on shk_pkg.
`default_nettype none

module shk_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_end_of_key,
    output      logic              o_in_ready,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire shk_pkg::t_dp_stat i_stat,
    output      shk_pkg::t_dp_cmd  o_cmd
);
    import shk_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;
    logic   w_load;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NOP;
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = w_slot_free;
                if (i_in_valid && w_slot_free) begin
                    if (i_end_of_key) begin
                        if (i_stat.is_mm) begin
                            o_cmd.op = DP_FIN1;
                            n_state  = ST_FIN2;
                        end else begin
                            o_cmd.op = DP_EMIT;
                            w_load   = 1'b1;
                        end
                    end else begin
                        o_cmd.op = DP_ABSORB;
                        if (i_stat.is_mm) begin
                            n_state = ST_MM_K2;
                        end
                    end
                end
            end
            ST_MM_K2: begin
                o_cmd.op = DP_MM_K2;
                n_state  = ST_MM_H;
            end
            ST_MM_H: begin
                o_cmd.op = DP_MM_H;
                n_state  = ST_IDLE;
            end
            ST_FIN2: begin
                o_cmd.op = DP_FIN2;
                n_state  = ST_FIN3;
            end
            ST_FIN3: begin
                if (w_slot_free) begin
                    o_cmd.op = DP_FIN3;
                    w_load   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
